>>> rtl/whbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whbs_pkg - shared types and constants for the water height box smoother
// Request structs for both channels, field widths, reset and arithmetic
// constants used by the smoother, its line-buffer RAM and its checker.
// ----------------------------------------------------------------------------
package whbs_pkg;

  // Field widths
  localparam int IN_W   = 16;  // Q10.6 input heights
  localparam int SURF_W = 17;  // Q11.6 surface height
  localparam int POS_W  = 10;  // result coordinates
  localparam int GW_W   = 11;  // grid_width register

  // Default grid limits
  localparam int MAX_WIDTH_DEF          = 1024;
  localparam logic [GW_W-1:0] GW_RESET  = 11'd512;

  // Line-buffer word: older row in the upper half, newer row in the lower
  localparam int LB_W = 2 * SURF_W;

  // Rounded divide by nine: q = floor((sum + 9*2^20 + 4) * RECIP9 >> 27).
  // The bias keeps the dividend positive; the 2^20 offset it adds to the
  // quotient vanishes in the low 17 bits.
  localparam int DIV_W                 = 24;
  localparam logic [DIV_W-1:0] DIV_BIAS = 24'd9437188;
  localparam logic [DIV_W-1:0] RECIP9   = 24'd14913081;
  localparam int RECIP_SH              = 27;
  localparam int PROD_W                = 2 * DIV_W;

  typedef struct packed {
    logic signed [IN_W-1:0] ground_height;
    logic signed [IN_W-1:0] water_depth;
    logic                   frame_start;
  } in_t;

  typedef struct packed {
    logic signed [SURF_W-1:0] smoothed_height;
    logic [POS_W-1:0]         centre_row;
    logic [POS_W-1:0]         centre_col;
    logic                     last;
  } out_t;

  // Result coordinates travelling with an item down the pipe
  typedef struct packed {
    logic [POS_W-1:0] centre_row;
    logic [POS_W-1:0] centre_col;
    logic             last;
  } meta_t;

endpackage

>>> rtl/water_height_box_smooth.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// water_height_box_smooth - 3x3 box smoother of the water surface height
// Raster stream of grid cells in, one smoothed cell out per interior cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_item): one cell per request in
//   raster order; frame_start puts the cell at row 0, column 0.
//   Output channel (out_valid / out_ready / out_item): one request for each
//   cell at row >= 2 and column >= 2, carrying the rounded mean of the 3x3
//   surface heights around the cell one row up and one column left.
//   Border cells produce nothing. cfg_wr_en / cfg_wr_data set grid_width
//   (clamped to 3..MAX_WIDTH); write it only while the block is idle.
// Timing:
//   A result passes stage 1, stage 2 and the output register in turn.
//   One cell per cycle unless the output stalls; the figure comes from the
//   line-buffer RAM, read once and written once per cell on separate ports.
// Reset:
//   Position counters clear, grid_width returns to 512, the pipe empties.
//   The line buffers are not cleared; each row is written before it is read.
// Stall:
//   A stalled result waits in the output register while the stages behind
//   it keep filling; in_ready drops only once they are all occupied.
// ----------------------------------------------------------------------------
module water_height_box_smooth #(
  parameter int MAX_WIDTH = whbs_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [whbs_pkg::GW_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  whbs_pkg::in_t             in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output whbs_pkg::out_t            out_item
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = (AW + 1 > whbs_pkg::GW_W) ? AW + 1 : whbs_pkg::GW_W;
  localparam int SW = whbs_pkg::SURF_W;
  localparam int DW = whbs_pkg::DIV_W;
  localparam int PW = whbs_pkg::POS_W;

  // Configuration and position
  logic [whbs_pkg::GW_W-1:0] grid_width;
  logic [AW-1:0]             col_count;
  logic [AW-1:0]             row_count;

  logic [CW-1:0] w_eff, w_m1;
  logic [CW-1:0] col_in, row_in, col_cur, row_cur, col_nxt, row_nxt;
  logic [CW-1:0] row_dec, col_dec;

  // Pipeline control
  logic v1, v2;
  logic adv_o, adv2, adv1, acc, go1, go2;

  // Stage 1: cell in flight, line-buffer data arriving
  logic signed [SW-1:0] s1;
  logic [AW-1:0]        addr1;
  logic                 prod1;
  whbs_pkg::meta_t      meta1;
  logic                 fwd;
  logic [SW-1:0]        fwd_older, fwd_newer;
  logic [whbs_pkg::LB_W-1:0] lb_rdata;
  logic [SW-1:0]        older_eff, newer_eff;
  logic [SW-1:0]        sum_in;

  // Column sums of the window, oldest column dropped as it slides
  logic [SW+1:0] cs1, cs2, colnew;
  logic [SW+2:0] pair;
  logic [DW-1:0] pair_bias, t1;

  // Stage 2: biased sum ready for the reciprocal multiply
  logic [DW-1:0]          t2;
  whbs_pkg::meta_t        meta2;
  logic [whbs_pkg::PROD_W-1:0] prod;

  // Effective width and position of the incoming cell
  always_comb begin
    if (CW'(grid_width) < CW'(3)) begin
      w_eff = CW'(3);
    end else if (CW'(grid_width) > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(grid_width);
    end
    w_m1 = w_eff - CW'(1);

    col_in = in_item.frame_start ? '0 : CW'(col_count);
    row_in = in_item.frame_start ? '0 : CW'(row_count);
    col_cur = col_in;
    row_cur = row_in;
    // position left outside a narrowed grid wraps first
    if (col_in >= w_eff) begin
      col_cur = '0;
      row_cur = row_in + CW'(1);
    end
    if (row_cur >= w_eff) begin
      row_cur = '0;
    end

    col_nxt = col_cur + CW'(1);
    row_nxt = row_cur;
    if (col_nxt >= w_eff) begin
      col_nxt = '0;
      row_nxt = row_cur + CW'(1);
      if (row_nxt >= w_eff) begin
        row_nxt = '0;
      end
    end
    row_dec = row_cur - CW'(1);
    col_dec = col_cur - CW'(1);
  end

  // Handshake: each stage moves when the one after it has room
  assign adv_o    = !out_valid || out_ready;
  assign adv2     = !v2 || adv_o;
  assign adv1     = !v1 || !prod1 || adv2;
  assign in_ready = adv1;
  assign acc      = in_valid && in_ready;
  assign go1      = v1 && adv1;
  assign go2      = v2 && adv_o;

  assign sum_in = {in_item.ground_height[15], in_item.ground_height}
                + {in_item.water_depth[15], in_item.water_depth};

  // Line buffers: {older row, newer row} per column
  whbs_ram #(
    .WIDTH (whbs_pkg::LB_W),
    .DEPTH (MAX_WIDTH)
  ) u_lb_ram (
    .clk   (clk),
    .we    (go1),
    .waddr (addr1),
    .wdata ({newer_eff, s1}),
    .re    (acc),
    .raddr (col_cur[AW-1:0]),
    .rdata (lb_rdata)
  );

  // Same column written by the cell just ahead: take its values
  assign older_eff = fwd ? fwd_older : lb_rdata[2*SW-1:SW];
  assign newer_eff = fwd ? fwd_newer : lb_rdata[SW-1:0];

  // New column sum, and the two kept columns plus the rounding bias
  always_comb begin
    colnew = {{2{older_eff[SW-1]}}, older_eff}
           + {{2{newer_eff[SW-1]}}, newer_eff}
           + {{2{s1[SW-1]}}, s1};
    pair      = {cs1[SW+1], cs1} + {cs2[SW+1], cs2};
    pair_bias = {{(DW-SW-3){pair[SW+2]}}, pair} + whbs_pkg::DIV_BIAS;
    t1        = {{(DW-SW-2){colnew[SW+1]}}, colnew} + pair_bias;
  end

  assign prod = whbs_pkg::PROD_W'(t2) * whbs_pkg::PROD_W'(whbs_pkg::RECIP9);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= whbs_pkg::GW_RESET;
      col_count  <= '0;
      row_count  <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      out_valid  <= 1'b0;
      fwd        <= 1'b0;
      cs1        <= '0;
      cs2        <= '0;
    end else begin
      if (cfg_wr_en) begin
        grid_width <= cfg_wr_data;
      end
      if (acc) begin
        col_count <= col_nxt[AW-1:0];
        row_count <= row_nxt[AW-1:0];
        fwd       <= v1 && (addr1 == col_cur[AW-1:0]);
      end
      if (go1) begin
        cs1 <= cs2;
        cs2 <= colnew;
      end
      v1        <= (v1 && !adv1) || acc;
      v2        <= (v2 && !adv_o) || (go1 && prod1);
      out_valid <= (out_valid && !out_ready) || go2;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      s1               <= sum_in;
      addr1            <= col_cur[AW-1:0];
      prod1            <= (row_cur >= CW'(2)) && (col_cur >= CW'(2));
      meta1.centre_row <= row_dec[PW-1:0];
      meta1.centre_col <= col_dec[PW-1:0];
      meta1.last       <= (row_cur == w_m1) && (col_cur == w_m1);
      fwd_older        <= newer_eff;
      fwd_newer        <= s1;
    end
    if (go1 && prod1) begin
      t2    <= t1;
      meta2 <= meta1;
    end
    if (go2) begin
      out_item.smoothed_height <= prod[whbs_pkg::RECIP_SH+SW-1:whbs_pkg::RECIP_SH];
      out_item.centre_row      <= meta2.centre_row;
      out_item.centre_col      <= meta2.centre_col;
      out_item.last            <= meta2.last;
    end
  end

endmodule

>>> rtl/whbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whbs_ram - simple dual-port RAM with registered read
// One write port and one read port; a read of the address being written in
// the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module whbs_ram #(
  parameter int WIDTH = whbs_pkg::LB_W,
  parameter int DEPTH = whbs_pkg::MAX_WIDTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/whbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whbs_checker - port-level checks for the water height box smoother
// Watches the top-level channels and is bound to every instance.
// ----------------------------------------------------------------------------
module whbs_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input whbs_pkg::out_t out_item
);

  // A stalled result request holds its payload
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Reset empties the output
  a_rst_empty : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // Input is refused only while a result waits on the receiver
  a_ready : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked with no stalled result");

  // Last interior cell of a square grid lies on the diagonal
  a_last_diag : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.last |-> out_item.centre_row == out_item.centre_col)
    else $error("last flag off the diagonal");

endmodule

bind water_height_box_smooth whbs_checker u_whbs_checker (.*);
